>>> rtl/core/mpeg_audio_header_finder_assert.svh
// assertion macros for the mpeg audio header finder
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef MPEG_AUDIO_HEADER_FINDER_ASSERT_SVH
`define MPEG_AUDIO_HEADER_FINDER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MAFH_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MAFH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define MAFH_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)

`define MAFH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/mafh_pkg.sv
// shared types, codes and lookup tables for the mpeg audio header finder
// no dependencies
`default_nettype none

package mafh_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int OFFSET_BITS = 16;

	// result status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_NO_SYNC      = 3'd1;
	localparam logic [2:0] ST_RESERVED_VER = 3'd2;
	localparam logic [2:0] ST_BAD_LAYER    = 3'd3;
	localparam logic [2:0] ST_OGG          = 3'd4;

	// version codes as reported
	localparam logic [1:0] VER_MPEG1  = 2'd0;
	localparam logic [1:0] VER_MPEG2  = 2'd1;
	localparam logic [1:0] VER_MPEG25 = 2'd2;

	// raw version field values
	localparam logic [1:0] VBITS_MPEG25   = 2'd0;
	localparam logic [1:0] VBITS_RESERVED = 2'd1;
	localparam logic [1:0] VBITS_MPEG2    = 2'd2;
	localparam logic [1:0] VBITS_MPEG1    = 2'd3;

	localparam logic [1:0] LBITS_RESERVED = 2'd0;
	localparam logic [1:0] MODE_MONO      = 2'd3;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [2:0] SYNC_TOP  = 3'b111;

	typedef enum logic {
		PH_DONE,
		PH_SEARCH
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]             status;
		logic [8:0]             bitrate_kbps;
		logic [15:0]            sample_rate_hz;
		logic [1:0]             version_code;
		logic [1:0]             layer_number;
		logic [1:0]             channel_mode;
		logic [1:0]             mode_extension;
		logic [1:0]             channel_count;
		logic                   crc_protected;
		logic                   padding_flag;
		logic [1:0]             emphasis_code;
		logic [OFFSET_BITS-1:0] header_offset;
	} out_item_t;

	// bitrate in kbit/s: [lsf][layer-1][index]
	localparam logic [8:0] RATE_TBL [2][3][16] = '{
		'{
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
				9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
				9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
				9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
		},
		'{
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
				9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
				9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
				9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
		}
	};

	// sample rate in Hz: [version][index]
	localparam logic [15:0] FREQ_TBL [3][4] = '{
		'{16'd44100, 16'd48000, 16'd32000, 16'd0},
		'{16'd22050, 16'd24000, 16'd16000, 16'd0},
		'{16'd11025, 16'd12000, 16'd8000,  16'd0}
	};

	// leading bytes of an ogg page
	localparam logic [7:0] OGG_SIG [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

	function automatic logic [8:0] rate_kbps(input logic lsf, input logic [1:0] layer,
		input logic [3:0] idx);
		logic [8:0] r;
		r = '0;
		if (layer != 2'd0) begin
			r = RATE_TBL[lsf][2'(layer - 2'd1)][idx];
		end
		return r;
	endfunction

	function automatic logic [15:0] freq_lookup(input logic [1:0] ver, input logic [1:0] idx);
		logic [15:0] r;
		r = '0;
		if (ver != 2'd3) begin
			r = FREQ_TBL[ver][idx];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/mafh_decode.sv
// decodes the three bytes that follow a frame's 0xFF sync byte into result fields
// depends on mafh_pkg
`default_nettype none

module mafh_decode
	import mafh_pkg::*;
(
	input  wire logic [7:0] hdr_b1,
	input  wire logic [7:0] hdr_b2,
	input  wire logic [7:0] hdr_b3,
	output out_item_t       fields
);

	logic [1:0] vbits;
	logic [1:0] lbits;
	logic [1:0] ver;
	logic [1:0] layer;
	logic [8:0] kbps;
	logic [1:0] mode;

	assign vbits = hdr_b1[4:3];
	assign lbits = hdr_b1[2:1];
	assign mode  = hdr_b3[7:6];

	always_comb begin
		case (vbits)
			VBITS_MPEG1: ver = VER_MPEG1;
			VBITS_MPEG2: ver = VER_MPEG2;
			default:     ver = VER_MPEG25;
		endcase
	end

	// layer field counts down: 3 is layer one
	assign layer = 2'(3'd4 - {1'b0, lbits});
	assign kbps  = rate_kbps(ver != VER_MPEG1, layer, hdr_b2[7:4]);

	always_comb begin
		fields = '0;
		if (vbits == VBITS_RESERVED) begin
			fields.status = ST_RESERVED_VER;
		end else if (lbits == LBITS_RESERVED || kbps == 9'd0) begin
			fields.status = ST_BAD_LAYER;
		end else begin
			fields.status         = ST_OK;
			fields.bitrate_kbps   = kbps;
			fields.sample_rate_hz = freq_lookup(ver, hdr_b2[3:2]);
			fields.version_code   = ver;
			fields.layer_number   = layer;
			fields.channel_mode   = mode;
			fields.mode_extension = hdr_b3[5:4];
			fields.channel_count  = (mode == MODE_MONO) ? 2'd1 : 2'd2;
			fields.crc_protected  = ~hdr_b1[0];
			fields.padding_flag   = hdr_b2[1];
			fields.emphasis_code  = hdr_b3[1:0];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mafh_scan.sv
// search state: byte window, position, ogg match and phase; judges one byte per step
// depends on mafh_pkg and mafh_decode
`default_nettype none

module mafh_scan
	import mafh_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire in_item_t  item,
	output logic           res_valid,
	output out_item_t      res
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	logic [23:0]              window_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     ogg_q;
	phase_t                   phase_q;

	logic [23:0]              window_e;
	logic [POSITION_BITS-1:0] pos_e;
	logic                     ogg_e;
	phase_t                   phase_e;
	phase_t                   phase_d;

	logic                     active;
	logic                     ogg_now;
	logic                     is_ogg;
	logic                     is_sync;
	logic [POSITION_BITS-1:0] pos_m3;
	logic [OFFSET_BITS-1:0]   offset;
	out_item_t                dec;

	// a first byte restarts the search before it is judged
	assign window_e = item.first_byte ? 24'd0 : window_q;
	assign pos_e    = item.first_byte ? '0 : pos_q;
	assign ogg_e    = item.first_byte ? 1'b1 : ogg_q;
	assign phase_e  = item.first_byte ? PH_SEARCH : phase_q;
	assign active   = step && (phase_e == PH_SEARCH);

	always_comb begin
		ogg_now = ogg_e;
		if (pos_e < POSITION_BITS'(4) && item.data_byte != OGG_SIG[pos_e[1:0]]) begin
			ogg_now = 1'b0;
		end
	end

	assign is_ogg  = (pos_e == POSITION_BITS'(3)) && ogg_now;
	assign is_sync = (pos_e >= POSITION_BITS'(3)) && (window_e[23:16] == SYNC_BYTE)
		&& (window_e[15:13] == SYNC_TOP);

	mafh_decode u_decode (
		.hdr_b1 (window_e[15:8]),
		.hdr_b2 (window_e[7:0]),
		.hdr_b3 (item.data_byte),
		.fields (dec)
	);

	assign pos_m3 = pos_e - POSITION_BITS'(3);

	// sync offset saturates, and pins high once the position counter has saturated
	generate
		if (POSITION_BITS > OFFSET_BITS) begin : g_wide_pos
			assign offset = (pos_e == POS_MAX || (|pos_m3[POSITION_BITS-1:OFFSET_BITS]))
				? '1 : pos_m3[OFFSET_BITS-1:0];
		end else begin : g_narrow_pos
			assign offset = (pos_e == POS_MAX) ? '1 : OFFSET_BITS'(pos_m3);
		end
	endgenerate

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			phase_d = res_valid ? PH_DONE : phase_e;
		end
	end

	// result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (active) begin
			if (is_ogg) begin
				res_valid  = 1'b1;
				res.status = ST_OGG;
			end else if (is_sync) begin
				res_valid         = 1'b1;
				res               = dec;
				res.header_offset = offset;
			end else if (item.last_byte) begin
				res_valid  = 1'b1;
				res.status = ST_NO_SYNC;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q    <= '0;
			ogg_q    <= 1'b1;
			phase_q  <= PH_DONE;
		end else begin
			phase_q <= phase_d;
			if (active) begin
				window_q <= {window_e[15:0], item.data_byte};
				ogg_q    <= ogg_now;
				pos_q    <= (pos_e == POS_MAX) ? pos_e : pos_e + POSITION_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mpeg_audio_header_finder.sv
// MPEG audio frame header finder. Bytes of a buffer enter on the byte channel, one
// request per cycle, with first_byte marking the start of each buffer; exactly one
// result per buffer leaves on the header channel: an Ogg rejection on the fourth byte,
// the decoded header on the fourth byte of the first header with an 11-bit sync, or "no sync" on
// last_byte. Bytes after the result and before the next first_byte are dropped.
// Each byte passes through an input register and then one judging step into the
// result register, so a result is registered in the result register when its deciding
// byte is judged; the sustained rate is one byte per cycle, held back only while a result
// waits unaccepted in the result register and a byte sits in the input register.
// top level; depends on mafh_pkg, mafh_scan, mafh_decode and the assertion macro header
`default_nettype none

`include "mpeg_audio_header_finder_assert.svh"

module mpeg_audio_header_finder
	import mafh_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	output logic           byte_ready,
	input  wire in_item_t  byte_item,
	output logic           header_valid,
	input  wire logic      header_ready,
	output out_item_t      header_item
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	logic      advance;
	logic      step;
	logic      res_valid;
	out_item_t res;

	// result register is free or is being taken this cycle
	assign advance    = !out_valid_q || header_ready;
	assign byte_ready = !valid_s1 || advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	mafh_scan #(
		.POSITION_BITS (POSITION_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign header_valid = out_valid_q;
	assign header_item  = out_q;

	`MAFH_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !header_valid, byte_ready, "byte channel stalled with empty result register")
	`MAFH_ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !advance, valid_s1, "stalled byte lost from input register")
	`MAFH_ASSERT_IMPLY(a_ogg_clean, clk, arst_n, header_valid && header_item.status == ST_OGG, header_item.bitrate_kbps == 9'd0 && header_item.header_offset == '0, "ogg result carries header fields")
	`MAFH_ASSERT_IMPLY(a_ok_fields, clk, arst_n, header_valid && header_item.status == ST_OK, header_item.layer_number != 2'd0 && header_item.bitrate_kbps != 9'd0, "ok result without layer or bitrate")

endmodule

`default_nettype wire
